FILE: rtl/gst_pkg.sv
// gst_pkg: shared types and constants of the gradient sharpen/threshold core.
// Used by gradient_sharpen_threshold_core; no dependencies.
`default_nettype none

package gst_pkg;

	// configuration register widths and reset values
	localparam int MODE_W   = 2;
	localparam int THRESH_W = 9;
	localparam int BOOST_W  = 8;
	localparam int LWIDTH_W = 11;
	localparam int FHEIGHT_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 3;

	localparam logic [THRESH_W-1:0]  THRESH_RESET  = 9'd30;
	localparam logic [BOOST_W-1:0]   BOOST_RESET   = 8'd100;
	localparam logic [LWIDTH_W-1:0]  LWIDTH_RESET  = 11'd640;
	localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 13'd480;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BOOST     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LWIDTH    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FHEIGHT   = 3'd4;

	// output modes; the unused code behaves as MODE_BOOST
	localparam logic [MODE_W-1:0] MODE_BOOST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BINARY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd2;

	// pixel and gradient arithmetic
	localparam int PIX_W  = 8;
	localparam int SQ_W   = 2 * PIX_W;
	localparam int SUM_W  = SQ_W + 1;
	localparam int MAG_W  = 9;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
	localparam logic [SUM_W-1:0] ROOT_BIT_TOP = 17'h10000;
	localparam logic [MAG_W-1:0] MAG_LIMIT = 9'd360;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/gst_ram.sv
// gst_ram: generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module gst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/gradient_sharpen_threshold_core.sv
// gradient_sharpen_threshold_core: gradient magnitude sharpening of a gray pixel stream.
// Depends on gst_pkg and gst_ram (previous-row line store).
//
//  port group   | direction | beat / write condition
//  -------------+-----------+-----------------------------------------------
//  pixel_in     | in        | in_valid && in_ready
//  pixel_out,   | out       | out_valid && out_ready
//  end_of_line, |           |
//  end_of_frame |           |
//  cfg_*        | in        | cfg_write (no handshake, no read-back)
//
// Sequencing: one pixel in flight; a border pixel passes accept and line-store read,
// read data and result, an interior pixel accept, squaring, sum, nine square-root
// steps and result; the output register loads at the last of them.
// Reset clears counters, left pixel, configuration registers and output valid; the line store
// keeps no reset. A stalled output beat holds the core in its result cycle, but a
// new pixel is taken while the previous result still waits in the output register.
`default_nettype none

module gradient_sharpen_threshold_core
	import gst_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [PIX_W-1:0]       pixel_in,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [PIX_W-1:0]       pixel_out,
	output logic                        end_of_line,
	output logic                        end_of_frame,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// configuration
	logic [MODE_W-1:0]    mode_q;
	logic [THRESH_W-1:0]  threshold_q;
	logic [BOOST_W-1:0]   boost_q;
	logic [LWIDTH_W-1:0]  line_width_q;
	logic [FHEIGHT_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_BOOST;
			threshold_q    <= THRESH_RESET;
			boost_q        <= BOOST_RESET;
			line_width_q   <= LWIDTH_RESET;
			frame_height_q <= FHEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MODE:      mode_q         <= cfg_data[MODE_W-1:0];
				REG_THRESHOLD: threshold_q    <= cfg_data[THRESH_W-1:0];
				REG_BOOST:     boost_q        <= cfg_data[BOOST_W-1:0];
				REG_LWIDTH:    line_width_q   <= cfg_data[LWIDTH_W-1:0];
				REG_FHEIGHT:   frame_height_q <= cfg_data[FHEIGHT_W-1:0];
				default:       ;
			endcase
		end
	end

	// geometry: last column and last row after clamping to 1..MAX
	logic [CW-1:0] last_col;
	logic [RW-1:0] last_row_idx;

	always_comb begin
		if (line_width_q == '0) begin
			last_col = '0;
		end else if (32'(line_width_q) > 32'(MAX_WIDTH)) begin
			last_col = CW'(MAX_WIDTH - 1);
		end else begin
			last_col = CW'(32'(line_width_q) - 32'd1);
		end
		if (frame_height_q == '0) begin
			last_row_idx = '0;
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			last_row_idx = RW'(MAX_HEIGHT - 1);
		end else begin
			last_row_idx = RW'(32'(frame_height_q) - 32'd1);
		end
	end

	// control
	state_t state_q, state_d;
	logic   in_beat;
	logic   ram_re;
	logic   ram_we;
	logic   load_out;
	logic   out_valid_q;

	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [PIX_W-1:0] left_pixel_q;

	// per-item registers
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] left_q;
	logic [CW-1:0]    idx_q;
	logic             border_q;
	logic             eol_q;
	logic             eof_q;

	logic [PIX_W-1:0] up_pixel;
	logic [SQ_W-1:0]  sq_x_s1;
	logic [SQ_W-1:0]  sq_y_s1;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] root_q;
	logic [SUM_W-1:0] bit_q;

	logic             eol_now;
	logic             last_row_now;

	assign eol_now      = col_q >= last_col;
	assign last_row_now = row_q >= last_row_idx;

	gst_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (pix_q),
		.re    (ram_re),
		.raddr (col_q),
		.rdata (up_pixel)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_READ;
			ST_READ:   state_d = border_q ? ST_DONE : ST_SQUARE;
			ST_SQUARE: state_d = ST_ROOT;
			ST_ROOT:   if (bit_q[0]) state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ram_re   = in_valid;
			end
			ST_READ:   ram_we = 1'b1;
			ST_SQUARE: ;
			ST_ROOT:   ;
			ST_DONE:   load_out = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	assign in_beat = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			left_pixel_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_beat) begin
				left_pixel_q <= pixel_in;
				if (eol_now) begin
					col_q <= '0;
					row_q <= last_row_now ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// capture the item and run the datapath
	logic [PIX_W-1:0] dx;
	logic [PIX_W-1:0] dy;
	logic [SUM_W:0]   trial;

	assign dx    = (pix_q >= left_q)   ? pix_q - left_q   : left_q - pix_q;
	assign dy    = (pix_q >= up_pixel) ? pix_q - up_pixel : up_pixel - pix_q;
	assign trial = {1'b0, root_q} + {1'b0, bit_q};

	always_ff @(posedge clk) begin
		if (in_beat) begin
			pix_q    <= pixel_in;
			left_q   <= left_pixel_q;
			idx_q    <= col_q;
			eol_q    <= eol_now;
			eof_q    <= eol_now && last_row_now;
			border_q <= (row_q == '0) || last_row_now || (col_q == '0) || eol_now;
		end
		case (state_q)
			ST_READ: begin
				sq_x_s1 <= SQ_W'(dx) * SQ_W'(dx);
				sq_y_s1 <= SQ_W'(dy) * SQ_W'(dy);
			end
			ST_SQUARE: begin
				rem_q  <= SUM_W'(sq_x_s1) + SUM_W'(sq_y_s1);
				root_q <= '0;
				bit_q  <= ROOT_BIT_TOP;
			end
			ST_ROOT: begin
				// one digit of the square root per cycle
				if ({1'b0, rem_q} >= trial) begin
					rem_q  <= rem_q - trial[SUM_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
	end

	// result selection
	logic [MAG_W-1:0]   mag;
	logic [MAG_W:0]     boosted;
	logic [PIX_W-1:0]   result;

	assign mag     = root_q[MAG_W-1:0];
	assign boosted = {1'b0, mag} + (MAG_W+1)'(boost_q);

	always_comb begin
		if (border_q) begin
			result = PIX_MAX;
		end else begin
			case (mode_q)
				MODE_BINARY: result = (mag > threshold_q) ? PIX_MAX : '0;
				MODE_EDGE:   result = (mag > threshold_q) ? PIX_MAX : pix_q;
				default: begin
					if (mag >= threshold_q) begin
						result = (boosted > (MAG_W+1)'(PIX_MAX)) ? PIX_MAX
							: boosted[PIX_W-1:0];
					end else begin
						result = pix_q;
					end
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_out    <= result;
			end_of_line  <= eol_q;
			end_of_frame <= eof_q;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_READ))
		else $error("accepted pixel did not start a line-store read");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(ram_re))
		else $error("line-store write without a preceding read");

	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> $onehot(bit_q))
		else $error("square-root step bit lost");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !border_q) |-> (root_q <= SUM_W'(MAG_LIMIT)))
		else $error("gradient magnitude out of range");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("output loaded outside the result cycle");

endmodule

`default_nettype wire
